[rtl/qdh_pkg.sv]
// qdh_pkg: shared types and constants of the QUIC DCID extract/hash block.
// No dependencies; qdh_ctrl, qdh_datapath and the top level import this package.
`default_nettype none

package qdh_pkg;

   localparam int LEN_W  = 5;
   localparam int HASH_W = 32;
   localparam int SLOT_W = 20;
   localparam int CSR_W  = 32;
   localparam int IDX_W  = 2;

   localparam logic [HASH_W-1:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;
   localparam logic [7:0]        HDR_FIXED_BIT = 8'h40;
   localparam logic [7:0]        HDR_LONG_BIT  = 8'h80;
   localparam logic [LEN_W-1:0]  LONG_LEN_OFFSET = 5'd5;
   localparam logic [LEN_W-1:0]  POS_MAX = 5'd31;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_SVC_KEY       = 2'd0;
   localparam logic [IDX_W-1:0] CSR_SHORT_CID_LEN = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MAGLEV_SIZE   = 2'd2;

   typedef enum logic [1:0] {
      ST_LONG     = 2'd0,
      ST_SHORT    = 2'd1,
      ST_NOT_QUIC = 2'd2,
      ST_TRUNC    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_LONG_HDR,
      PH_CID,
      PH_DONE,
      PH_NOT_QUIC,
      PH_PAD,
      PH_MOD,
      PH_OUT
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      status_type        status;
      logic [LEN_W-1:0]  cid_length;
      logic [HASH_W-1:0] aff_hash;
      logic [SLOT_W-1:0] slot;
      logic              slot_valid;
   } rsp_word_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [CSR_W-1:0] value;
   } csr_word_type;

   typedef struct packed {
      logic       take;
      logic       pkt_end;
      logic       init_pkt;
      logic       init_short;
      logic       begin_long;
      logic       cid_byte;
      logic       pad_step;
      logic       mod_start;
      logic       mod_step;
      logic       load_imm;
      status_type imm_status;
      logic       load_done;
   } dp_cmd_type;

   typedef struct packed {
      logic fixed_bit;
      logic long_bit;
      logic sh_len_ok;
      logic long_len_ok;
      logic at_len_offset;
      logic cid_last;
      logic pad_done;
      logic mod_done;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

[rtl/qdh_stream_if.sv]
// qdh_stream_if: valid/ready channel carrying one word of a given payload type.
// Payload types come from qdh_pkg.
`default_nettype none

interface qdh_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/qdh_ctrl.sv]
// qdh_ctrl: parse/finish state machine of the DCID extract/hash block.
// Depends on qdh_pkg; drives datapath commands from datapath status.
`default_nettype none

module qdh_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_fire,
   input  wire                 req_last,
   input  qdh_pkg::dp_stat_type stat,
   output logic                req_ready,
   output qdh_pkg::dp_cmd_type cmd
);
   import qdh_pkg::*;

   phase_type state_ff, state_in;
   phase_type take_phase;
   logic      in_parse;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_FIRST;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_parse = (state_ff == PH_FIRST) || (state_ff == PH_LONG_HDR) ||
                     (state_ff == PH_CID) || (state_ff == PH_DONE) ||
                     (state_ff == PH_NOT_QUIC);

   // parse phase after the current byte
   always_comb begin
      take_phase = state_ff;
      unique case (state_ff)
         PH_FIRST: begin
            if (!stat.fixed_bit) take_phase = PH_NOT_QUIC;
            else if (stat.long_bit) take_phase = PH_LONG_HDR;
            else if (stat.sh_len_ok) take_phase = PH_CID;
            else take_phase = PH_NOT_QUIC;
         end
         PH_LONG_HDR: begin
            if (stat.at_len_offset) begin
               take_phase = stat.long_len_ok ? PH_CID : PH_NOT_QUIC;
            end
         end
         PH_CID: begin
            if (stat.cid_last) take_phase = PH_DONE;
         end
         default: take_phase = state_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PH_FIRST, PH_LONG_HDR, PH_CID, PH_DONE, PH_NOT_QUIC: begin
            if (req_fire) begin
               if (req_last) state_in = (take_phase == PH_DONE) ? PH_PAD : PH_FIRST;
               else state_in = take_phase;
            end
         end
         PH_PAD: if (stat.pad_done) state_in = PH_MOD;
         PH_MOD: if (stat.mod_done) state_in = PH_OUT;
         PH_OUT: if (stat.out_free) state_in = PH_FIRST;
         default: state_in = PH_FIRST;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.imm_status = (take_phase == PH_NOT_QUIC) ? ST_NOT_QUIC : ST_TRUNC;
      req_ready  = in_parse && stat.out_free;
      cmd.take    = req_fire;
      cmd.pkt_end = req_fire && req_last;
      unique case (state_ff)
         PH_FIRST: begin
            cmd.init_pkt   = req_fire;
            cmd.init_short = req_fire && stat.fixed_bit && !stat.long_bit &&
                             stat.sh_len_ok;
         end
         PH_LONG_HDR: begin
            cmd.begin_long = req_fire && stat.at_len_offset && stat.long_len_ok;
         end
         PH_CID:  cmd.cid_byte = req_fire;
         PH_PAD: begin
            cmd.pad_step  = !stat.pad_done;
            cmd.mod_start = stat.pad_done;
         end
         PH_MOD:  cmd.mod_step  = 1'b1;
         PH_OUT:  cmd.load_done = stat.out_free;
         default: cmd.take = req_fire;
      endcase
      cmd.load_imm = req_fire && req_last && in_parse && (take_phase != PH_DONE);
   end

endmodule

`default_nettype wire

[rtl/qdh_datapath.sv]
// qdh_datapath: registers, FNV-1a hash, CID counters, slot divider, result register.
// Depends on qdh_pkg; commanded by qdh_ctrl.
`default_nettype none

module qdh_datapath #(
   parameter int MAX_CID_BYTES = 20
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  qdh_pkg::csr_word_type csr_word,
   input  qdh_pkg::req_word_type req_word,
   input  qdh_pkg::dp_cmd_type   cmd,
   input  wire                   rsp_ready,
   output qdh_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   output qdh_pkg::rsp_word_type rsp_word
);
   import qdh_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CID_BYTES);

   // registers
   logic [HASH_W-1:0] svc_key_ff, svc_key_in;
   logic [LEN_W-1:0]  sh_len_ff, sh_len_in;
   logic [SLOT_W-1:0] maglev_ff, maglev_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  target_ff, target_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   status_type        decided_ff, decided_in;
   logic [HASH_W-1:0] div_ff, div_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0]  bit_ff, bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [HASH_W-1:0] hash_base;
   logic [HASH_W-1:0] mul_a;
   logic [HASH_W-1:0] mul_p;
   logic [HASH_W-1:0] hash_fixed;
   logic [SLOT_W:0]   rem_trial;
   logic [7:0]        b;
   logic              out_free;

   assign b         = req_word.payload_byte;
   assign hash_base = FNV_OFFSET ^ svc_key_ff;
   assign hash_fixed = (hash_ff == '0) ? HASH_W'(1) : hash_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rem_trial = {rem_ff, div_ff[HASH_W-1]};

   // one shared multiply by the FNV prime
   always_comb begin
      priority if (cmd.init_short) mul_a = hash_base ^ HASH_W'(sh_len_ff);
      else if (cmd.begin_long || cmd.cid_byte) mul_a = hash_ff ^ HASH_W'(b);
      else mul_a = hash_ff;
   end
   assign mul_p = mul_a * FNV_PRIME;

   always_comb begin
      stat.fixed_bit     = (b & HDR_FIXED_BIT) != 8'd0;
      stat.long_bit      = (b & HDR_LONG_BIT) != 8'd0;
      stat.sh_len_ok     = (sh_len_ff != '0) && (sh_len_ff <= MAX_LEN);
      stat.long_len_ok   = (b != 8'd0) && (b <= 8'(MAX_CID_BYTES));
      stat.at_len_offset = pos_ff == LONG_LEN_OFFSET;
      stat.cid_last      = ({1'b0, cnt_ff} + 6'd1) >= {1'b0, target_ff};
      stat.pad_done      = cnt_ff >= MAX_LEN;
      stat.mod_done      = bit_ff == POS_MAX;
      stat.out_free      = out_free;
   end

   always_comb begin
      svc_key_in = svc_key_ff;
      sh_len_in  = sh_len_ff;
      maglev_in  = maglev_ff;
      if (csr_we) begin
         unique case (csr_word.index)
            CSR_SVC_KEY:       svc_key_in = csr_word.value;
            CSR_SHORT_CID_LEN: sh_len_in  = csr_word.value[LEN_W-1:0];
            CSR_MAGLEV_SIZE:   maglev_in  = csr_word.value[SLOT_W-1:0];
            default:           svc_key_in = svc_key_ff;
         endcase
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      target_in  = target_ff;
      hash_in    = hash_ff;
      decided_in = decided_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      bit_in     = bit_ff;

      if (cmd.pkt_end) pos_in = '0;
      else if (cmd.take && pos_ff != POS_MAX) pos_in = pos_ff + LEN_W'(1);

      priority if (cmd.init_pkt) begin
         cnt_in     = '0;
         target_in  = cmd.init_short ? sh_len_ff : '0;
         hash_in    = cmd.init_short ? mul_p : hash_base;
         decided_in = stat.long_bit ? ST_LONG : ST_SHORT;
      end else if (cmd.begin_long) begin
         cnt_in    = '0;
         target_in = b[LEN_W-1:0];
         hash_in   = mul_p;
      end else if (cmd.cid_byte || cmd.pad_step) begin
         cnt_in  = cnt_ff + LEN_W'(1);
         hash_in = mul_p;
      end else if (cmd.mod_start) begin
         hash_in = hash_fixed;
         div_in  = hash_fixed;
         rem_in  = '0;
         bit_in  = '0;
      end else if (cmd.mod_step) begin
         // restoring division, one quotient bit per cycle
         div_in = {div_ff[HASH_W-2:0], 1'b0};
         bit_in = bit_ff + LEN_W'(1);
         if (rem_trial >= {1'b0, maglev_ff}) begin
            rem_in = SLOT_W'(rem_trial - {1'b0, maglev_ff});
         end else begin
            rem_in = rem_trial[SLOT_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_imm) begin
         rsp_valid_in       = 1'b1;
         rsp_word_in        = '0;
         rsp_word_in.status = cmd.imm_status;
      end else if (cmd.load_done) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.status     = decided_ff;
         rsp_word_in.cid_length = target_ff;
         rsp_word_in.aff_hash   = hash_ff;
         rsp_word_in.slot_valid = maglev_ff != '0;
         rsp_word_in.slot       = (maglev_ff != '0) ? rem_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svc_key_ff    <= '0;
         sh_len_ff     <= '0;
         maglev_ff     <= '0;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         target_ff     <= '0;
         hash_ff       <= '0;
         decided_ff    <= ST_LONG;
         bit_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         svc_key_ff    <= svc_key_in;
         sh_len_ff     <= sh_len_in;
         maglev_ff     <= maglev_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         target_ff     <= target_in;
         hash_ff       <= hash_in;
         decided_ff    <= decided_in;
         bit_ff        <= bit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

[rtl/quic_dcid_extract_hash.sv]
// quic_dcid_extract_hash: top level of the QUIC DCID extractor and FNV-1a hasher.
// Depends on qdh_pkg, qdh_stream_if, qdh_ctrl and qdh_datapath.
//
//   channel  dir  word                                        handshake
//   req_if   in   payload_byte[8], last_byte                  valid/ready
//   rsp_if   out  status, cid_length, aff_hash, slot, slot_valid  valid/ready
//   csr_if   in   index[2], value[32]                         valid/ready (always ready)
//
// Bytes are taken one per cycle, except while a finished packet is padded and
// divided. After the last byte of a packet whose CID completed, the hash is
// padded one multiply per cycle up to MAX_CID_BYTES bytes, then a restoring
// divider forms the slot as the hash modulo the Maglev size. Not-QUIC and
// truncated packets give their word in the cycle after the last byte.
// Synchronous reset zeroes all but the divider and result word; no clearing pass.
// Input is stalled while the result register holds a word that is not taken.
`default_nettype none

module quic_dcid_extract_hash #(
   parameter int MAX_CID_BYTES = 20
) (
   input  wire          clock,
   input  wire          reset,
   qdh_stream_if.sink   req_if,
   qdh_stream_if.source rsp_if,
   qdh_stream_if.sink   csr_if
);
   import qdh_pkg::*;

   dp_cmd_type   cmd;
   dp_stat_type  stat;
   req_word_type req_word;
   csr_word_type csr_word;
   rsp_word_type rsp_word;
   logic         req_ready;
   logic         req_fire;
   logic         rsp_valid;

   assign req_word = req_word_type'(req_if.data);
   assign csr_word = csr_word_type'(csr_if.data);

   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;
   assign req_fire     = req_if.valid && req_ready;

   qdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_last  (req_word.last_byte),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   qdh_datapath #(
      .MAX_CID_BYTES (MAX_CID_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_if.valid),
      .csr_word  (csr_word),
      .req_word  (req_word),
      .cmd       (cmd),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_if.valid = rsp_valid;
   assign rsp_if.data  = rsp_word;

endmodule

`default_nettype wire
